// ----- hdl/pfa_pkg.sv -----
// Shared types, codes and constants for the page first-fit allocator.
// No dependencies; every other file but pfa_ram refers to it by scoped names.
`default_nettype none

package pfa_pkg;

    localparam int DEF_PAGE_UNITS = 2048;
    localparam int WORD_W         = 16;
    localparam int VAL_W          = 18;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOROOM = 2'd1;
    localparam logic [1:0] STAT_WHOLE  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [11:0] size_bytes;
        logic [3:0]  align_log2;
        logic [10:0] block_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] alloc_offset;
        logic [11:0] free_left;
    } rsp_t;

    typedef struct packed {
        logic in_ready;
        logic res_valid;
        rsp_t res;
    } seq_out_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FB_RD0,
        S_FB_RD1,
        S_FB_RD2,
        S_BS_WR0,
        S_BS_WR1,
        S_A_TOP,
        S_A_EVAL,
        S_A_HEAD,
        S_A_REREAD,
        S_A_FIT0,
        S_A_FIT,
        S_A_LINK,
        S_A_TAIL,
        S_A_DONE,
        S_F_HEADM,
        S_F_WALK,
        S_F_MERGEN,
        S_F_PCHK0,
        S_F_PCHK1,
        S_F_PB,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/pfa_req_if.sv -----
// Request channel of the page allocator: valid/ready handshake with a req_t payload.
// Depends on pfa_pkg.
`default_nettype none

interface pfa_req_if;
    logic          valid;
    logic          ready;
    pfa_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/pfa_rsp_if.sv -----
// Response channel of the page allocator: valid/ready handshake with a rsp_t payload.
// Depends on pfa_pkg.
`default_nettype none

interface pfa_rsp_if;
    logic          valid;
    logic          ready;
    pfa_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/pfa_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- hdl/pfa_seq.sv -----
// Sequencer of the page allocator: walks and edits the in-page free list
// through the page RAM, one word access per cycle. Depends on pfa_pkg.
`default_nettype none

module pfa_seq #(
    parameter int PAGE_UNITS = pfa_pkg::DEF_PAGE_UNITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire pfa_pkg::req_t                 req_data,
    input  wire logic                          res_take,
    output pfa_pkg::seq_out_t                  so,
    output logic                               mem_we,
    output logic [$clog2(PAGE_UNITS)-1:0]      mem_addr,
    output logic [pfa_pkg::WORD_W-1:0]         mem_wdata,
    input  wire logic [pfa_pkg::WORD_W-1:0]    mem_rdata
);

    localparam int AW = $clog2(PAGE_UNITS);
    localparam int CW = $clog2(PAGE_UNITS + 1);
    localparam int IW = $clog2(PAGE_UNITS + 2);
    localparam pfa_pkg::val_t PAGE_V   = pfa_pkg::val_t'(PAGE_UNITS);
    localparam pfa_pkg::val_t ONE_V    = pfa_pkg::val_t'(1);
    localparam logic [AW-1:0] CLR_LAST = AW'(PAGE_UNITS - 1);

    function automatic pfa_pkg::val_t norm_next(input pfa_pkg::val_t n);
        return (n <= 0 || n >= PAGE_V) ? PAGE_V : n;
    endfunction

    function automatic logic in_page(input pfa_pkg::val_t x);
        return (x >= 0) && (x < PAGE_V);
    endfunction

    pfa_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [AW-1:0]   clr_reg, clr_next;
    pfa_pkg::val_t   fb_addr_reg, fb_addr_next, fb_v_reg, fb_v_next;
    logic            fb_oob_reg, fb_oob_next;
    pfa_pkg::val_t   fb_size_reg, fb_size_next, fb_nx_reg, fb_nx_next;
    pfa_pkg::val_t   bs_addr_reg, bs_addr_next, bs_size_reg, bs_size_next;
    pfa_pkg::val_t   bs_nx_reg, bs_nx_next;
    logic            func_reg, func_next;
    pfa_pkg::val_t   units_reg, units_next, b_reg, b_next;
    logic            a_on_reg, a_on_next, a_page_reg, a_page_next;
    logic [3:0]      a_sh_reg, a_sh_next;
    pfa_pkg::val_t   cur_reg, cur_next, prev_reg, prev_next;
    logic            prev_ok_reg, prev_ok_next;
    logic [IW-1:0]   it_reg, it_next;
    pfa_pkg::val_t   avail_reg, avail_next, nxt_reg, nxt_next;
    pfa_pkg::val_t   aligned_reg, aligned_next, delta_reg, delta_next;
    pfa_pkg::val_t   sz_prev_reg, sz_prev_next;
    pfa_pkg::val_t   head_reg, head_next;
    logic [CW-1:0]   fc_reg, fc_next;
    logic            partly_reg, partly_next;
    logic [1:0]      status_reg, status_next;
    logic [10:0]     aoff_reg, aoff_next;

    pfa_pkg::val_t rdv, fb_addr1, bs_addr1, mask_c, aligned_c, delta_c, target_c;
    pfa_pkg::val_t fc_ext, sum_fc, b_end;
    logic          fit_c, exact_c, top_fail, walk_go, merge_nx, merge_prev;
    logic          acc;
    logic [12:0]   half_up;
    logic [3:0]    sh_in;

    assign acc      = (state_reg == pfa_pkg::S_IDLE) && req_valid;
    assign rdv      = fb_oob_reg ? '0 : pfa_pkg::val_t'($signed(mem_rdata));
    assign fb_addr1 = fb_addr_reg + ONE_V;
    assign bs_addr1 = bs_addr_reg + ONE_V;
    assign mask_c   = (ONE_V << a_sh_reg) - ONE_V;
    always_comb
    begin
        if (!a_on_reg)
            aligned_c = cur_reg;
        else if (a_page_reg)
            aligned_c = (cur_reg == 0) ? '0 : PAGE_V;
        else
            aligned_c = (cur_reg + mask_c) & ~mask_c;
    end
    assign delta_c    = aligned_c - cur_reg;
    assign fit_c      = fb_size_reg >= units_reg + delta_c;
    assign exact_c    = avail_reg == units_reg;
    assign target_c   = exact_c ? nxt_reg : cur_reg + units_reg;
    assign top_fail   = (it_reg > IW'(PAGE_UNITS)) || !in_page(cur_reg);
    assign walk_go    = (b_reg > fb_nx_reg) && (it_reg <= IW'(PAGE_UNITS));
    assign merge_nx   = (fb_nx_reg != PAGE_V) && (b_reg + units_reg == fb_nx_reg);
    assign merge_prev = prev_reg + fb_size_reg == b_reg;
    assign fc_ext     = pfa_pkg::val_t'(fc_reg);
    assign sum_fc     = fc_ext + units_reg;
    assign b_end      = b_reg + units_reg;
    assign half_up    = ({1'b0, req_data.size_bytes} + 13'd1) >> 1;
    assign sh_in      = req_data.align_log2 - 4'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::S_CLEAR:
                if (clr_reg == CLR_LAST) state_next = pfa_pkg::S_IDLE;
            pfa_pkg::S_IDLE:
                if (acc) state_next = pfa_pkg::S_DECODE;
            pfa_pkg::S_DECODE:
            begin
                if (func_reg == pfa_pkg::FN_ALLOC)
                    state_next = (partly_reg && fc_ext >= units_reg) ?
                                 pfa_pkg::S_A_TOP : pfa_pkg::S_DONE;
                else if (sum_fc > PAGE_V)
                    state_next = pfa_pkg::S_DONE;
                else if (sum_fc == PAGE_V)
                    state_next = pfa_pkg::S_BS_WR0;
                else if (b_end > PAGE_V)
                    state_next = pfa_pkg::S_DONE;
                else if (!partly_reg)
                    state_next = pfa_pkg::S_BS_WR0;
                else if (b_reg < head_reg)
                    state_next = (b_end == head_reg) ? pfa_pkg::S_FB_RD0 : pfa_pkg::S_BS_WR0;
                else
                    state_next = pfa_pkg::S_FB_RD0;
            end
            pfa_pkg::S_FB_RD0:   state_next = pfa_pkg::S_FB_RD1;
            pfa_pkg::S_FB_RD1:   state_next = (rdv < 0) ? ret_reg : pfa_pkg::S_FB_RD2;
            pfa_pkg::S_FB_RD2:   state_next = ret_reg;
            pfa_pkg::S_BS_WR0:   state_next = (bs_size_reg > 1) ? pfa_pkg::S_BS_WR1 : ret_reg;
            pfa_pkg::S_BS_WR1:   state_next = ret_reg;
            pfa_pkg::S_A_TOP:    state_next = top_fail ? pfa_pkg::S_DONE : pfa_pkg::S_FB_RD0;
            pfa_pkg::S_A_EVAL:
            begin
                if (fit_c)
                    state_next = (delta_c != 0) ? pfa_pkg::S_BS_WR0 : pfa_pkg::S_A_FIT;
                else
                    state_next = (fb_nx_reg == PAGE_V) ? pfa_pkg::S_DONE : pfa_pkg::S_A_TOP;
            end
            pfa_pkg::S_A_HEAD:   state_next = pfa_pkg::S_BS_WR0;
            pfa_pkg::S_A_REREAD: state_next = pfa_pkg::S_FB_RD0;
            pfa_pkg::S_A_FIT0:   state_next = pfa_pkg::S_A_FIT;
            pfa_pkg::S_A_FIT:
            begin
                if (prev_ok_reg)
                    state_next = pfa_pkg::S_FB_RD0;
                else
                    state_next = exact_c ? pfa_pkg::S_A_DONE : pfa_pkg::S_BS_WR0;
            end
            pfa_pkg::S_A_LINK:   state_next = pfa_pkg::S_BS_WR0;
            pfa_pkg::S_A_TAIL:   state_next = pfa_pkg::S_BS_WR0;
            pfa_pkg::S_A_DONE:   state_next = pfa_pkg::S_DONE;
            pfa_pkg::S_F_HEADM:  state_next = pfa_pkg::S_BS_WR0;
            pfa_pkg::S_F_WALK:
                state_next = (walk_go || merge_nx) ? pfa_pkg::S_FB_RD0 : pfa_pkg::S_BS_WR0;
            pfa_pkg::S_F_MERGEN: state_next = pfa_pkg::S_BS_WR0;
            pfa_pkg::S_F_PCHK0:  state_next = pfa_pkg::S_FB_RD0;
            pfa_pkg::S_F_PCHK1:
                state_next = merge_prev ? pfa_pkg::S_FB_RD0 : pfa_pkg::S_BS_WR0;
            pfa_pkg::S_F_PB:     state_next = pfa_pkg::S_BS_WR0;
            pfa_pkg::S_DONE:
                if (res_take) state_next = pfa_pkg::S_IDLE;
            default:             state_next = pfa_pkg::S_IDLE;
        endcase
    end

    // datapath updates; fb_* is the block-fetch helper, bs_* the block-store helper
    always_comb
    begin
        ret_next     = ret_reg;
        clr_next     = clr_reg;
        fb_addr_next = fb_addr_reg;
        fb_v_next    = fb_v_reg;
        fb_oob_next  = fb_oob_reg;
        fb_size_next = fb_size_reg;
        fb_nx_next   = fb_nx_reg;
        bs_addr_next = bs_addr_reg;
        bs_size_next = bs_size_reg;
        bs_nx_next   = bs_nx_reg;
        func_next    = func_reg;
        units_next   = units_reg;
        b_next       = b_reg;
        a_on_next    = a_on_reg;
        a_page_next  = a_page_reg;
        a_sh_next    = a_sh_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        it_next      = it_reg;
        avail_next   = avail_reg;
        nxt_next     = nxt_reg;
        aligned_next = aligned_reg;
        delta_next   = delta_reg;
        sz_prev_next = sz_prev_reg;
        head_next    = head_reg;
        fc_next      = fc_reg;
        partly_next  = partly_reg;
        status_next  = status_reg;
        aoff_next    = aoff_reg;
        case (state_reg)
            pfa_pkg::S_CLEAR:
                clr_next = clr_reg + 1'b1;
            pfa_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    func_next   = req_data.func;
                    units_next  = (half_up == 13'd0) ? ONE_V : pfa_pkg::val_t'(half_up);
                    b_next      = pfa_pkg::val_t'(req_data.block_offset);
                    a_on_next   = req_data.align_log2 > 4'd1;
                    a_sh_next   = sh_in;
                    a_page_next = (ONE_V << sh_in) >= PAGE_V;
                    status_next = pfa_pkg::STAT_OK;
                    aoff_next   = '0;
                end
            end
            pfa_pkg::S_DECODE:
            begin
                if (func_reg == pfa_pkg::FN_ALLOC)
                begin
                    if (partly_reg && fc_ext >= units_reg)
                    begin
                        prev_ok_next = 1'b0;
                        cur_next     = head_reg;
                        it_next      = '0;
                    end
                    else
                        status_next = pfa_pkg::STAT_NOROOM;
                end
                else if (sum_fc > PAGE_V)
                begin
                    status_next = pfa_pkg::STAT_OK;
                end
                else if (sum_fc == PAGE_V)
                begin
                    head_next    = '0;
                    fc_next      = CW'(PAGE_UNITS);
                    partly_next  = 1'b1;
                    status_next  = pfa_pkg::STAT_WHOLE;
                    bs_addr_next = '0;
                    bs_size_next = PAGE_V;
                    bs_nx_next   = PAGE_V;
                    ret_next     = pfa_pkg::S_DONE;
                end
                else if (b_end > PAGE_V)
                begin
                    status_next = pfa_pkg::STAT_OK;
                end
                else if (!partly_reg)
                begin
                    fc_next      = CW'(units_reg);
                    head_next    = b_reg;
                    partly_next  = 1'b1;
                    bs_addr_next = b_reg;
                    bs_size_next = units_reg;
                    bs_nx_next   = PAGE_V;
                    ret_next     = pfa_pkg::S_DONE;
                end
                else
                begin
                    fc_next = CW'(sum_fc);
                    if (b_reg < head_reg)
                    begin
                        if (b_end == head_reg)
                        begin
                            fb_addr_next = head_reg;
                            ret_next     = pfa_pkg::S_F_HEADM;
                        end
                        else
                        begin
                            bs_addr_next = b_reg;
                            bs_size_next = units_reg;
                            bs_nx_next   = head_reg;
                            head_next    = b_reg;
                            ret_next     = pfa_pkg::S_DONE;
                        end
                    end
                    else
                    begin
                        prev_next    = head_reg;
                        it_next      = '0;
                        fb_addr_next = head_reg;
                        ret_next     = pfa_pkg::S_F_WALK;
                    end
                end
            end
            pfa_pkg::S_FB_RD0:
                fb_oob_next = !in_page(fb_addr_reg);
            pfa_pkg::S_FB_RD1:
            begin
                if (rdv < 0)
                begin
                    fb_size_next = ONE_V;
                    fb_nx_next   = norm_next(-rdv);
                end
                else
                begin
                    fb_v_next   = rdv;
                    fb_oob_next = !in_page(fb_addr1);
                end
            end
            pfa_pkg::S_FB_RD2:
            begin
                fb_size_next = (fb_v_reg > 0) ? fb_v_reg : ONE_V;
                fb_nx_next   = norm_next(rdv);
            end
            pfa_pkg::S_A_TOP:
            begin
                if (top_fail)
                    status_next = pfa_pkg::STAT_NOROOM;
                else
                begin
                    fb_addr_next = cur_reg;
                    ret_next     = pfa_pkg::S_A_EVAL;
                end
            end
            pfa_pkg::S_A_EVAL:
            begin
                if (fit_c)
                begin
                    if (delta_c != 0)
                    begin
                        aligned_next = aligned_c;
                        delta_next   = delta_c;
                        bs_addr_next = aligned_c;
                        bs_size_next = fb_size_reg - delta_c;
                        bs_nx_next   = fb_nx_reg;
                        ret_next     = pfa_pkg::S_A_HEAD;
                    end
                    else
                    begin
                        avail_next = fb_size_reg;
                        nxt_next   = fb_nx_reg;
                    end
                end
                else if (fb_nx_reg == PAGE_V)
                    status_next = pfa_pkg::STAT_NOROOM;
                else
                begin
                    prev_next    = cur_reg;
                    prev_ok_next = 1'b1;
                    cur_next     = fb_nx_reg;
                    it_next      = it_reg + 1'b1;
                end
            end
            pfa_pkg::S_A_HEAD:
            begin
                // alignment head stays free in front of the aligned block
                bs_addr_next = cur_reg;
                bs_size_next = delta_reg;
                bs_nx_next   = aligned_reg;
                ret_next     = pfa_pkg::S_A_REREAD;
            end
            pfa_pkg::S_A_REREAD:
            begin
                prev_next    = cur_reg;
                prev_ok_next = 1'b1;
                cur_next     = aligned_reg;
                fb_addr_next = aligned_reg;
                ret_next     = pfa_pkg::S_A_FIT0;
            end
            pfa_pkg::S_A_FIT0:
            begin
                avail_next = fb_size_reg;
                nxt_next   = fb_nx_reg;
            end
            pfa_pkg::S_A_FIT:
            begin
                if (prev_ok_reg)
                begin
                    fb_addr_next = prev_reg;
                    ret_next     = pfa_pkg::S_A_LINK;
                end
                else
                begin
                    head_next    = target_c;
                    bs_addr_next = cur_reg + units_reg;
                    bs_size_next = avail_reg - units_reg;
                    bs_nx_next   = nxt_reg;
                    ret_next     = pfa_pkg::S_A_DONE;
                end
            end
            pfa_pkg::S_A_LINK:
            begin
                bs_addr_next = prev_reg;
                bs_size_next = fb_size_reg;
                bs_nx_next   = target_c;
                ret_next     = exact_c ? pfa_pkg::S_A_DONE : pfa_pkg::S_A_TAIL;
            end
            pfa_pkg::S_A_TAIL:
            begin
                bs_addr_next = cur_reg + units_reg;
                bs_size_next = avail_reg - units_reg;
                bs_nx_next   = nxt_reg;
                ret_next     = pfa_pkg::S_A_DONE;
            end
            pfa_pkg::S_A_DONE:
            begin
                fc_next     = CW'(fc_ext - units_reg);
                partly_next = fc_ext != units_reg;
                aoff_next   = cur_reg[10:0];
            end
            pfa_pkg::S_F_HEADM:
            begin
                units_next   = units_reg + fb_size_reg;
                bs_addr_next = b_reg;
                bs_size_next = units_reg + fb_size_reg;
                bs_nx_next   = fb_nx_reg;
                head_next    = b_reg;
                ret_next     = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_F_WALK:
            begin
                if (walk_go)
                begin
                    prev_next    = fb_nx_reg;
                    it_next      = it_reg + 1'b1;
                    fb_addr_next = fb_nx_reg;
                    ret_next     = pfa_pkg::S_F_WALK;
                end
                else if (merge_nx)
                begin
                    fb_addr_next = fb_nx_reg;
                    ret_next     = pfa_pkg::S_F_MERGEN;
                end
                else
                begin
                    bs_addr_next = b_reg;
                    bs_size_next = units_reg;
                    bs_nx_next   = fb_nx_reg;
                    ret_next     = pfa_pkg::S_F_PCHK0;
                end
            end
            pfa_pkg::S_F_MERGEN:
            begin
                units_next   = units_reg + fb_size_reg;
                bs_addr_next = b_reg;
                bs_size_next = units_reg + fb_size_reg;
                bs_nx_next   = fb_nx_reg;
                ret_next     = pfa_pkg::S_F_PCHK0;
            end
            pfa_pkg::S_F_PCHK0:
            begin
                fb_addr_next = prev_reg;
                ret_next     = pfa_pkg::S_F_PCHK1;
            end
            pfa_pkg::S_F_PCHK1:
            begin
                sz_prev_next = fb_size_reg;
                if (merge_prev)
                begin
                    fb_addr_next = b_reg;
                    ret_next     = pfa_pkg::S_F_PB;
                end
                else
                begin
                    bs_addr_next = prev_reg;
                    bs_size_next = fb_size_reg;
                    bs_nx_next   = b_reg;
                    ret_next     = pfa_pkg::S_DONE;
                end
            end
            pfa_pkg::S_F_PB:
            begin
                bs_addr_next = prev_reg;
                bs_size_next = fb_size_reg + sz_prev_reg;
                bs_nx_next   = fb_nx_reg;
                ret_next     = pfa_pkg::S_DONE;
            end
            default:
            begin
                ret_next = ret_reg;
            end
        endcase
    end

    // outputs: handshake and RAM port
    always_comb
    begin
        so.in_ready         = state_reg == pfa_pkg::S_IDLE;
        so.res_valid        = state_reg == pfa_pkg::S_DONE;
        so.res.status       = status_reg;
        so.res.alloc_offset = aoff_reg;
        so.res.free_left    = 12'(fc_reg);
        mem_we              = 1'b0;
        mem_addr            = fb_addr_reg[AW-1:0];
        mem_wdata           = '0;
        case (state_reg)
            pfa_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = (clr_reg <= AW'(1)) ? pfa_pkg::WORD_W'(PAGE_UNITS) : '0;
            end
            pfa_pkg::S_FB_RD0:
                mem_addr = fb_addr_reg[AW-1:0];
            pfa_pkg::S_FB_RD1:
                mem_addr = fb_addr1[AW-1:0];
            pfa_pkg::S_BS_WR0:
            begin
                mem_we    = in_page(bs_addr_reg);
                mem_addr  = bs_addr_reg[AW-1:0];
                mem_wdata = (bs_size_reg > 1) ? bs_size_reg[pfa_pkg::WORD_W-1:0]
                                              : pfa_pkg::WORD_W'(-bs_nx_reg);
            end
            pfa_pkg::S_BS_WR1:
            begin
                mem_we    = in_page(bs_addr1);
                mem_addr  = bs_addr1[AW-1:0];
                mem_wdata = bs_nx_reg[pfa_pkg::WORD_W-1:0];
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pfa_pkg::S_CLEAR;
            ret_reg    <= pfa_pkg::S_IDLE;
            clr_reg    <= '0;
            head_reg   <= '0;
            fc_reg     <= CW'(PAGE_UNITS);
            partly_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            clr_reg    <= clr_next;
            head_reg   <= head_next;
            fc_reg     <= fc_next;
            partly_reg <= partly_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fb_addr_reg <= fb_addr_next;
        fb_v_reg    <= fb_v_next;
        fb_oob_reg  <= fb_oob_next;
        fb_size_reg <= fb_size_next;
        fb_nx_reg   <= fb_nx_next;
        bs_addr_reg <= bs_addr_next;
        bs_size_reg <= bs_size_next;
        bs_nx_reg   <= bs_nx_next;
        func_reg    <= func_next;
        units_reg   <= units_next;
        b_reg       <= b_next;
        a_on_reg    <= a_on_next;
        a_page_reg  <= a_page_next;
        a_sh_reg    <= a_sh_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        prev_ok_reg <= prev_ok_next;
        it_reg      <= it_next;
        avail_reg   <= avail_next;
        nxt_reg     <= nxt_next;
        aligned_reg <= aligned_next;
        delta_reg   <= delta_next;
        sz_prev_reg <= sz_prev_next;
        status_reg  <= status_next;
        aoff_reg    <= aoff_next;
    end

endmodule

`default_nettype wire

// ----- hdl/page_first_fit_allocator_unit.sv -----
// Page first-fit allocator: top level with page RAM, sequencer and response register.
// Depends on pfa_pkg, pfa_req_if, pfa_rsp_if, pfa_ram, pfa_seq.
//
// Usage:
//  req (sink): one beat per allocate or free request. rsp (source): one beat
//  per request, in request order, with status, allocated offset and free units.
//  After reset every word of the page RAM is swept once, writing the
//  whole-page free block; req.ready stays low until the sweep ends.
//  Requests are handled one at a time by the sequencer, which reaches the
//  free list only through the single RAM port, one word per cycle.
//  Each request passes setup, then where needed a walk over the free blocks
//  (by an allocation or a free), then the list edits. A failed allocation
//  with too few free units answers straight after setup.
//  The response sits in an output register; the next request is taken while
//  it waits. If rsp.ready stays low, the following request finishes and
//  holds in the sequencer until the register frees up.
`default_nettype none

module page_first_fit_allocator_unit #(
    parameter int PAGE_UNITS = pfa_pkg::DEF_PAGE_UNITS
) (
    input wire logic clk,
    input wire logic rst_n,
    pfa_req_if.sink   req,
    pfa_rsp_if.source rsp
);

    localparam int AW = $clog2(PAGE_UNITS);

    pfa_pkg::seq_out_t          so;
    logic                       mem_we;
    logic [AW-1:0]              mem_addr;
    logic [pfa_pkg::WORD_W-1:0] mem_wdata, mem_rdata;
    logic                       res_take;
    logic                       out_valid_reg, out_valid_next;
    pfa_pkg::rsp_t              out_data_reg, out_data_next;

    pfa_ram #(
        .WIDTH (pfa_pkg::WORD_W),
        .DEPTH (PAGE_UNITS)
    ) u_page_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    pfa_seq #(
        .PAGE_UNITS (PAGE_UNITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_data  (req.data),
        .res_take  (res_take),
        .so        (so),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    assign res_take  = !out_valid_reg || rsp.ready;
    assign req.ready = so.in_ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (so.res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = so.res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- hdl/pfa_chk.sv -----
// Port-level checker for the page allocator, bound to the top level.
// Depends on pfa_pkg and page_first_fit_allocator_unit.
`default_nettype none

module pfa_chk #(
    parameter int PAGE_UNITS = pfa_pkg::DEF_PAGE_UNITS
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire pfa_pkg::rsp_t rsp_data
);

    logic [1:0] pend_reg, pend_next;
    logic       req_beat, rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (req_beat && !rsp_beat)
            pend_next = pend_reg + 2'd1;
        else if (rsp_beat && !req_beat)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // one request in the sequencer plus one in the response register at most
    a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response beat without a request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    a_whole: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == pfa_pkg::STAT_WHOLE |->
            rsp_data.free_left == 12'(PAGE_UNITS) && rsp_data.alloc_offset == 11'd0)
        else $error("wholly free page reported with wrong count");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status == pfa_pkg::STAT_OK ||
                      rsp_data.status == pfa_pkg::STAT_NOROOM ||
                      rsp_data.status == pfa_pkg::STAT_WHOLE)
        else $error("bad status code");

endmodule

bind page_first_fit_allocator_unit pfa_chk #(
    .PAGE_UNITS (PAGE_UNITS)
) u_pfa_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
